FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on a full property, disabled while the active-low reset is asserted
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// Clocked same-cycle implication, disabled while the active-low reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

FILE: src/dmx_pkg.sv
package dmx_pkg;

  // Sample formats held in the format register
  typedef enum logic [1:0] {
    FMT_FLOAT32 = 2'd0,
    FMT_INT16   = 2'd1,
    FMT_INT32   = 2'd2,
    FMT_NONE    = 2'd3
  } fmt_e;

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_e;

  localparam int WORDS_PER_FRAME = 8;
  localparam int WORD_W          = 32;
  localparam int CNT_W           = 4;
  localparam int REM_W           = 3;

  // Lane value is Q31 scaled, float lanes clamp to +-2^59
  localparam int LANE_W     = 61;
  localparam int LANE_MAG_W = 60;
  localparam logic [LANE_MAG_W-1:0] LANE_LIMIT = 60'h800000000000000;

  // Adder tree: three add levels plus one magnitude stage
  localparam int SUM_STAGES = 4;
  localparam int SUM_W      = 64;

  // Divider: magnitude split into digits, one group per stage
  localparam int MAG_W      = 64;
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEP   = MAG_W / DIV_STAGES;

  localparam logic [WORD_W-1:0] Q31_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] Q31_MIN = 32'h8000_0000;

  localparam fmt_e             FMT_RESET   = FMT_INT16;
  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd2;

endpackage

FILE: src/dmx_lane.sv
module dmx_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  dmx_pkg::fmt_e                       fmt_i,
  input  logic [dmx_pkg::WORD_W-1:0]          word_i,
  output logic signed [dmx_pkg::LANE_W-1:0]   lane_o
);

  logic signed [dmx_pkg::LANE_W-1:0] lane_d, lane_q;
  logic        [dmx_pkg::LANE_MAG_W-1:0] mag;
  logic        [7:0]  expo;
  logic        [22:0] man;
  logic        [23:0] mant;
  logic        [5:0]  shl;
  logic        [7:0]  rsh;
  logic signed [dmx_pkg::LANE_W-1:0] fval;

  // float32 to Q31: value * 2^31 = mant * 2^(exp - 119), truncated toward zero
  always_comb begin
    expo = word_i[30:23];
    man  = word_i[22:0];
    mant = {1'b1, man};
    shl  = 6'(expo - 8'd119);
    rsh  = 8'd119 - expo;
    mag  = '0;
    if (expo == 8'hff) begin
      // infinity clamps, NaN reads as zero
      mag = (man == '0) ? dmx_pkg::LANE_LIMIT : '0;
    end else if (expo == 8'h00) begin
      mag = '0;
    end else if (expo >= 8'd119) begin
      if (expo > 8'd154) begin
        mag = dmx_pkg::LANE_LIMIT;
      end else begin
        mag = {36'd0, mant} << shl;
      end
    end else begin
      if (rsh >= 8'd32) begin
        mag = '0;
      end else begin
        mag = {36'd0, mant >> rsh[4:0]};
      end
    end
    fval = word_i[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Format select; int16 is scaled up by 2^16 to reach Q31
  always_comb begin
    case (fmt_i)
      dmx_pkg::FMT_FLOAT32: lane_d = fval;
      dmx_pkg::FMT_INT16:
        lane_d = {{(dmx_pkg::LANE_W-32){word_i[15]}}, word_i[15:0], 16'd0};
      dmx_pkg::FMT_INT32:
        lane_d = {{(dmx_pkg::LANE_W-dmx_pkg::WORD_W){word_i[31]}}, word_i};
      default: lane_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: src/dmx_sum.sv
module dmx_sum (
  input  logic                                clk_i,
  input  logic [dmx_pkg::SUM_STAGES-1:0]      en_i,
  input  logic signed [dmx_pkg::LANE_W-1:0]   lanes_i [dmx_pkg::WORDS_PER_FRAME],
  output logic [dmx_pkg::MAG_W-1:0]           mag_o,
  output logic                                neg_o
);

  localparam int L1_W = dmx_pkg::LANE_W + 1;
  localparam int L2_W = dmx_pkg::LANE_W + 2;

  logic signed [L1_W-1:0]          sum1_q [4];
  logic signed [L2_W-1:0]          sum2_q [2];
  logic signed [dmx_pkg::SUM_W-1:0] sum3_q;
  logic [dmx_pkg::MAG_W-1:0]       mag_q;
  logic                            neg_q;

  // Registered pairwise adder tree
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 4; i++) begin
        sum1_q[i] <= L1_W'(lanes_i[2*i]) + L1_W'(lanes_i[2*i+1]);
      end
    end
    if (en_i[1]) begin
      for (int i = 0; i < 2; i++) begin
        sum2_q[i] <= L2_W'(sum1_q[2*i]) + L2_W'(sum1_q[2*i+1]);
      end
    end
    if (en_i[2]) begin
      sum3_q <= dmx_pkg::SUM_W'(sum2_q[0]) + dmx_pkg::SUM_W'(sum2_q[1]);
    end
    // sign and magnitude for the unsigned divider
    if (en_i[3]) begin
      neg_q <= sum3_q[dmx_pkg::SUM_W-1];
      mag_q <= sum3_q[dmx_pkg::SUM_W-1] ? dmx_pkg::MAG_W'(-sum3_q)
                                        : dmx_pkg::MAG_W'(sum3_q);
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

FILE: src/dmx_div.sv
module dmx_div (
  input  logic                               clk_i,
  input  logic [dmx_pkg::DIV_STAGES:0]       en_i,
  input  logic [dmx_pkg::CNT_W-1:0]          n_i,
  input  logic [dmx_pkg::MAG_W-1:0]          mag_i,
  input  logic                               neg_i,
  output logic signed [dmx_pkg::WORD_W-1:0]  sample_o,
  output logic                               sat_o
);

  localparam int NS = dmx_pkg::DIV_STAGES;

  logic [dmx_pkg::MAG_W-1:0] work_q [NS];
  logic [dmx_pkg::REM_W-1:0] rem_q  [NS];
  logic                      neg_q  [NS];

  // Restoring long division by a small divisor, DIV_STEP quotient bits per stage.
  // Dividend bits shift out the top, quotient bits shift in at the bottom.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [dmx_pkg::MAG_W-1:0] w_in, w_d;
    logic [dmx_pkg::REM_W-1:0] r_in, r_d;
    logic                      neg_in;

    if (k == 0) begin : g_first
      assign w_in   = mag_i;
      assign r_in   = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign w_in   = work_q[k-1];
      assign r_in   = rem_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    always_comb begin
      logic [dmx_pkg::REM_W:0] t;
      w_d = w_in;
      r_d = r_in;
      t   = '0;
      for (int b = 0; b < dmx_pkg::DIV_STEP; b++) begin
        t = {r_d, w_d[dmx_pkg::MAG_W-1]};
        if (t >= n_i) begin
          w_d = {w_d[dmx_pkg::MAG_W-2:0], 1'b1};
          r_d = dmx_pkg::REM_W'(t - n_i);
        end else begin
          w_d = {w_d[dmx_pkg::MAG_W-2:0], 1'b0};
          r_d = t[dmx_pkg::REM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        work_q[k] <= w_d;
        rem_q[k]  <= r_d;
        neg_q[k]  <= neg_in;
      end
    end
  end

  logic [dmx_pkg::MAG_W-1:0]  quo;
  logic                       quo_neg;
  logic [dmx_pkg::WORD_W-1:0] smp_d, smp_q;
  logic                       sat_d, sat_q;

  // Reapply sign and clamp to Q1.31; only float sums can reach the clamp
  always_comb begin
    quo     = work_q[NS-1];
    quo_neg = neg_q[NS-1];
    sat_d   = 1'b0;
    if (!quo_neg && (quo > dmx_pkg::MAG_W'(dmx_pkg::Q31_MAX))) begin
      smp_d = dmx_pkg::Q31_MAX;
      sat_d = 1'b1;
    end else if (quo_neg && (quo > dmx_pkg::MAG_W'(dmx_pkg::Q31_MIN))) begin
      smp_d = dmx_pkg::Q31_MIN;
      sat_d = 1'b1;
    end else begin
      smp_d = quo_neg ? (32'd0 - quo[dmx_pkg::WORD_W-1:0]) : quo[dmx_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NS]) begin
      smp_q <= smp_d;
      sat_q <= sat_d;
    end
  end

  assign sample_o = $signed(smp_q);
  assign sat_o    = sat_q;

endmodule

FILE: src/multichannel_mono_downmix.sv
// Mono downmix of one interleaved frame of up to eight channel words per transaction,
// as float32, int16 or int32 per the format register, to a saturating Q1.31 average.
// One frame is accepted every cycle unless a stalled output has backed up the pipeline;
// the frame enters the per-lane format conversion register at the accepting edge, then
// passes the registered adder tree and sign/magnitude stages, eight divider stages of
// eight quotient bits each, and the output register. Each stage holds its transaction
// while the stage after it is full and stalled, so stalls on the output side only back
// up the pipeline.
// Register 0 (address 0x0) is the sample format, register 1 (address 0x4) the channel
// count; the user must write both only while the block is idle, which is not enforced.
module multichannel_mono_downmix #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // frame input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_0_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_1_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_2_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_3_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_4_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_5_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_6_i,
  input  logic [dmx_pkg::WORD_W-1:0]         chan_word_7_i,
  input  logic                               frame_last_i,
  // mono output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dmx_pkg::WORD_W-1:0]  mono_sample_o,
  output logic                               mono_saturated_o,
  output logic                               mono_last_o
);

  localparam int NUM_LANES = (MAX_CHANNELS < dmx_pkg::WORDS_PER_FRAME) ?
                             MAX_CHANNELS : dmx_pkg::WORDS_PER_FRAME;
  localparam int NST       = 1 + dmx_pkg::SUM_STAGES + dmx_pkg::DIV_STAGES + 1;

  // Configuration registers
  dmx_pkg::fmt_e              fmt_q;
  logic [dmx_pkg::CNT_W-1:0]  cnt_q;
  logic                       cfg_wr;
  dmx_pkg::reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dmx_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dmx_pkg::FMT_RESET;
      cnt_q <= dmx_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dmx_pkg::REG_FORMAT: fmt_q <= dmx_pkg::fmt_e'(pwdata[1:0]);
        dmx_pkg::REG_COUNT:  cnt_q <= pwdata[dmx_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dmx_pkg::REG_FORMAT: prdata = {30'd0, fmt_q};
      dmx_pkg::REG_COUNT:  prdata = {28'd0, cnt_q};
      default:             prdata = '0;
    endcase
  end

  // Active channel count: zero reads as one, capped at the lane count
  logic [dmx_pkg::CNT_W-1:0] n_eff;

  always_comb begin
    if (cnt_q == '0) begin
      n_eff = dmx_pkg::CNT_W'(1);
    end else if (cnt_q > dmx_pkg::CNT_W'(NUM_LANES)) begin
      n_eff = dmx_pkg::CNT_W'(NUM_LANES);
    end else begin
      n_eff = cnt_q;
    end
  end

  // Pipeline occupancy and per-stage advance
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  logic [NST-1:0] last_q;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Frame-last marker travels alongside the data
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= frame_last_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign in_ready_o = en[0];

  // Lanes: one converter per channel the block is built for
  logic [dmx_pkg::WORD_W-1:0]        words  [dmx_pkg::WORDS_PER_FRAME];
  logic signed [dmx_pkg::LANE_W-1:0] lane_w [dmx_pkg::WORDS_PER_FRAME];

  assign words[0] = chan_word_0_i;
  assign words[1] = chan_word_1_i;
  assign words[2] = chan_word_2_i;
  assign words[3] = chan_word_3_i;
  assign words[4] = chan_word_4_i;
  assign words[5] = chan_word_5_i;
  assign words[6] = chan_word_6_i;
  assign words[7] = chan_word_7_i;

  logic [dmx_pkg::WORDS_PER_FRAME-1:0] lane_on;

  for (genvar l = 0; l < dmx_pkg::WORDS_PER_FRAME; l++) begin : g_lane
    if (l < NUM_LANES) begin : g_used
      logic signed [dmx_pkg::LANE_W-1:0] lane_raw;

      dmx_lane u_lane (
        .clk_i  (clk_i),
        .en_i   (en[0]),
        .fmt_i  (fmt_q),
        .word_i (words[l]),
        .lane_o (lane_raw)
      );

      // channels beyond the active count add nothing
      assign lane_on[l] = (dmx_pkg::CNT_W'(l) < n_eff);
      assign lane_w[l]  = lane_on[l] ? lane_raw : '0;
    end else begin : g_unused
      assign lane_on[l] = 1'b0;
      assign lane_w[l]  = lane_on[l] ? $signed({1'b0, words[l], 28'd0}) : '0;
    end
  end

  // Merge: adder tree then divide by the channel count
  logic [dmx_pkg::MAG_W-1:0] sum_mag;
  logic                      sum_neg;

  dmx_sum u_sum (
    .clk_i   (clk_i),
    .en_i    (en[dmx_pkg::SUM_STAGES:1]),
    .lanes_i (lane_w),
    .mag_o   (sum_mag),
    .neg_o   (sum_neg)
  );

  dmx_div u_div (
    .clk_i    (clk_i),
    .en_i     (en[NST-1 -: dmx_pkg::DIV_STAGES+1]),
    .n_i      (n_eff),
    .mag_i    (sum_mag),
    .neg_i    (sum_neg),
    .sample_o (mono_sample_o),
    .sat_o    (mono_saturated_o)
  );

  assign out_valid_o = v_q[NST-1];
  assign mono_last_o = last_q[NST-1];

endmodule

FILE: src/dmx_checker.sv
`include "assert_macros.svh"

module dmx_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_ready_o,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [31:0] mono_sample_o,
  input  logic               mono_saturated_o,
  input  logic               mono_last_o
);

  logic        out_stall;
  logic [33:0] out_payload;
  logic        on_rail;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {mono_sample_o, mono_saturated_o, mono_last_o};
  assign on_rail     = (mono_sample_o == dmx_pkg::Q31_MAX) ||
                       (mono_sample_o == dmx_pkg::Q31_MIN);

  // stalled result keeps its payload
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_payload))

  // a saturated average sits on one of the two rails
  `ASSERT_IMPL(a_sat_rail, clk_i, rst_ni, out_valid_o && mono_saturated_o, on_rail)

  // an open output register lets the whole pipeline advance
  `ASSERT_IMPL(a_ready_chain, clk_i, rst_ni, out_ready_i || !out_valid_o, in_ready_o)

endmodule

bind multichannel_mono_downmix dmx_checker u_dmx_checker (.*);

FILE: dv/tb.sv
module tb;

  localparam int MAX_CHANNELS   = 8;
  localparam int DRAIN_CYCLES   = 30;    // pipeline is 14 deep, plus margin
  localparam int STALL_LIMIT    = 4000;  // cycles with no transaction at all
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 115;
  localparam int RAND_PHASES    = 16;
  localparam int MAX_PRINTS     = 40;

  localparam longint unsigned LANE_CLAMP = 64'd1 << 59;
  localparam longint          Q31_HI     = 64'sd2147483647;
  localparam longint          Q31_LO     = -64'sd2147483648;

  typedef struct packed {
    logic [dmx_pkg::WORDS_PER_FRAME-1:0][dmx_pkg::WORD_W-1:0] word;
    logic                                                     last;
  } frame_t;

  typedef struct packed {
    logic [dmx_pkg::WORD_W-1:0] sample;
    logic                       sat;
    logic                       last;
  } mono_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // DUT inputs, known from time zero
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [2:0]                 paddr         = '0;
  logic [31:0]                pwdata        = '0;
  logic                       in_valid_i    = 1'b0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_0_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_1_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_2_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_3_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_4_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_5_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_6_i = '0;
  logic [dmx_pkg::WORD_W-1:0] chan_word_7_i = '0;
  logic                       frame_last_i  = 1'b0;
  logic                       out_ready_i   = 1'b0;

  // DUT outputs
  logic [31:0]                       prdata;
  logic                              pready;
  logic                              in_ready_o;
  logic                              out_valid_o;
  logic signed [dmx_pkg::WORD_W-1:0] mono_sample_o;
  logic                              mono_saturated_o;
  logic                              mono_last_o;

  multichannel_mono_downmix #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .chan_word_0_i    (chan_word_0_i),
    .chan_word_1_i    (chan_word_1_i),
    .chan_word_2_i    (chan_word_2_i),
    .chan_word_3_i    (chan_word_3_i),
    .chan_word_4_i    (chan_word_4_i),
    .chan_word_5_i    (chan_word_5_i),
    .chan_word_6_i    (chan_word_6_i),
    .chan_word_7_i    (chan_word_7_i),
    .frame_last_i     (frame_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mono_sample_o    (mono_sample_o),
    .mono_saturated_o (mono_saturated_o),
    .mono_last_o      (mono_last_o)
  );

  // shadow of the register file, updated on each APB write
  dmx_pkg::fmt_e cfg_fmt = dmx_pkg::FMT_RESET;
  logic [3:0]    cfg_cnt = dmx_pkg::COUNT_RESET;

  frame_t       frame_q[$];
  mono_result_t mono_exp_q[$];
  frame_t       cur_frame;

  int  frames_queued   = 0;
  int  frames_accepted = 0;
  int  results_checked = 0;
  int  mismatches      = 0;
  int  settings_used   = 0;
  int  send_idle_pct   = 0;
  int  recv_stall_pct  = 0;
  int  stall_req       = 0;
  int  stall_ack       = 0;
  int  hold_left       = 0;
  int  quiet_cycles    = 0;
  bit  send_hold       = 1'b0;
  bit  offering        = 1'b0;

  // float lane to Q31 scale, truncated toward zero, clamped to +-2^59
  function automatic longint float_lane_q31(logic [31:0] w);
    logic [7:0]      e;
    longint unsigned m;
    longint unsigned mag;
    int              s;
    e = w[30:23];
    m = {40'd0, 1'b1, w[22:0]};
    if (e == 8'hff) begin
      if (w[22:0] != 23'd0) return 0;  // NaN reads as zero
      mag = LANE_CLAMP;
    end else if (e == 8'h00) begin
      mag = 0;                         // subnormal is below one LSB
    end else begin
      s = int'(e) - 119;
      if (s > 35) mag = LANE_CLAMP;
      else if (s >= 0) mag = m << s;
      else if (-s >= 32) mag = 0;
      else mag = m >> (-s);
      if (mag > LANE_CLAMP) mag = LANE_CLAMP;
    end
    return w[31] ? -longint'(mag) : longint'(mag);
  endfunction

  // expected mono sample of one frame under the given settings
  function automatic mono_result_t predict_mono(frame_t fr, dmx_pkg::fmt_e f,
                                                logic [3:0] cnt);
    longint       n;
    longint       acc;
    longint       avg;
    mono_result_t r;
    n = (cnt == 4'd0) ? 1 : (int'(cnt) > MAX_CHANNELS) ? MAX_CHANNELS : int'(cnt);
    if (n > dmx_pkg::WORDS_PER_FRAME) n = dmx_pkg::WORDS_PER_FRAME;
    acc   = 0;
    avg   = 0;
    r.sat = 1'b0;
    for (int c = 0; c < dmx_pkg::WORDS_PER_FRAME; c++) begin
      if (c < n) begin
        case (f)
          dmx_pkg::FMT_FLOAT32: acc += float_lane_q31(fr.word[c]);
          dmx_pkg::FMT_INT16:   acc += longint'($signed(fr.word[c][15:0]));
          dmx_pkg::FMT_INT32:   acc += longint'($signed(fr.word[c]));
          default:     ;
        endcase
      end
    end
    case (f)
      dmx_pkg::FMT_FLOAT32: begin
        avg = acc / n;
        if (avg > Q31_HI) begin
          avg   = Q31_HI;
          r.sat = 1'b1;
        end else if (avg < Q31_LO) begin
          avg   = Q31_LO;
          r.sat = 1'b1;
        end
      end
      dmx_pkg::FMT_INT16: avg = (acc * 65536) / n;
      dmx_pkg::FMT_INT32: avg = acc / n;
      default:   avg = 0;
    endcase
    r.sample = avg[31:0];
    r.last   = fr.last;
    return r;
  endfunction

  // random channel word, biased toward the interesting values of each format
  function automatic logic [31:0] gen_word(dmx_pkg::fmt_e f);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(9))
          0: w = 32'h0000_0000;
          1: w = 32'hffff_ffff;
          2: w = 32'h3f80_0000;  // +1.0
          3: w = 32'hbf80_0000;  // -1.0
          4: w = 32'h7f80_0000;  // +inf
          5: w = 32'hff80_0000;  // -inf
          6: w = 32'h7fc0_0000;  // quiet NaN
          7: w = 32'h0000_0001;  // smallest subnormal
          8: w = dmx_pkg::Q31_MAX;
          default: w = dmx_pkg::Q31_MIN;
        endcase
      end
      1, 2, 3: begin
        if (f == dmx_pkg::FMT_FLOAT32) w[30:23] = 8'($urandom_range(160, 90));
      end
      4: begin
        if (f == dmx_pkg::FMT_INT16) w[15:0] = $urandom_range(1) ? 16'h7fff : 16'h8000;
        else w = $urandom_range(1) ? dmx_pkg::Q31_MAX : dmx_pkg::Q31_MIN;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic frame_t gen_frame(dmx_pkg::fmt_e f);
    frame_t      fr;
    logic [31:0] same;
    bit          all_same;
    same     = gen_word(f);
    all_same = ($urandom_range(4) == 0);
    for (int c = 0; c < dmx_pkg::WORDS_PER_FRAME; c++) begin
      fr.word[c] = all_same ? same : gen_word(f);
    end
    fr.last = 1'($urandom_range(1));
    return fr;
  endfunction

  task automatic push_frame(frame_t fr);
    frame_q.push_back(fr);
    frames_queued++;
  endtask

  // lanes 0 and 1 as given, the rest all the same word
  task automatic push_words(logic [31:0] w0, logic [31:0] w1, logic [31:0] wr, logic last);
    frame_t fr;
    for (int c = 0; c < dmx_pkg::WORDS_PER_FRAME; c++) fr.word[c] = wr;
    fr.word[0] = w0;
    fr.word[1] = w1;
    fr.last    = last;
    push_frame(fr);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result %0d, %s: got %08h, expected %08h",
               results_checked, field, got, want);
  endtask

  // APB write: setup, access, done when pready is seen with penable high
  task automatic apb_write(dmx_pkg::reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == dmx_pkg::REG_FORMAT) cfg_fmt = dmx_pkg::fmt_e'(data[1:0]);
    else cfg_cnt = data[3:0];
  endtask

  // block idle: every queued frame taken, every result back, pipeline flushed
  task automatic wait_idle();
    while (frames_accepted != frames_queued || mono_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(dmx_pkg::fmt_e f, logic [3:0] cnt);
    wait_idle();
    apb_write(dmx_pkg::REG_FORMAT, {30'd0, f});
    apb_write(dmx_pkg::REG_COUNT, {28'd0, cnt});
    settings_used++;
  endtask

  // input driver: predict on acceptance, then offer the next pending frame
  always @(posedge clk_i) begin : frame_driver
    logic fire;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        mono_exp_q.push_back(predict_mono(cur_frame, cfg_fmt, cfg_cnt));
        frames_accepted++;
        offering = 1'b0;
      end
      if (!in_valid_i || fire) begin
        if (frame_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          cur_frame      = frame_q.pop_front();
          offering       = 1'b1;
          in_valid_i    <= 1'b1;
          chan_word_0_i <= cur_frame.word[0];
          chan_word_1_i <= cur_frame.word[1];
          chan_word_2_i <= cur_frame.word[2];
          chan_word_3_i <= cur_frame.word[3];
          chan_word_4_i <= cur_frame.word[4];
          chan_word_5_i <= cur_frame.word[5];
          chan_word_6_i <= cur_frame.word[6];
          chan_word_7_i <= cur_frame.word[7];
          frame_last_i  <= cur_frame.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: check each result, drive ready with random or long stalls
  always @(posedge clk_i) begin : mono_monitor
    mono_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (mono_exp_q.size() == 0) begin
          report_mismatch("result with nothing expected", mono_sample_o, '0);
        end else begin
          want = mono_exp_q.pop_front();
          if (mono_sample_o !== want.sample)
            report_mismatch("mono_sample", mono_sample_o, want.sample);
          if (mono_saturated_o !== want.sat)
            report_mismatch("mono_saturated", {31'd0, mono_saturated_o}, {31'd0, want.sat});
          if (mono_last_o !== want.last)
            report_mismatch("mono_last", {31'd0, mono_last_o}, {31'd0, want.last});
        end
        results_checked++;
      end
      if (stall_ack != stall_req) begin
        stall_ack    = stall_req;
        hold_left    = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int            base;
    int            mode;
    dmx_pkg::fmt_e fmt_plan[4];
    int            cnt_plan[RAND_PHASES];
    fmt_plan = '{dmx_pkg::FMT_FLOAT32, dmx_pkg::FMT_INT16, dmx_pkg::FMT_INT32,
                 dmx_pkg::FMT_NONE};
    cnt_plan = '{8, 0, 1, 5, 0, 8, 2, 7, 15, 4, 1, 6, 3, 3, 8, 8};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // settings straight out of reset: int16, two channels
    push_words(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_words(32'habcd_7fff, 32'habcd_7fff, 32'habcd_7fff, 1'b1);
    push_words(32'h1234_8000, 32'h1234_8000, 32'h1234_8000, 1'b0);
    push_words(32'h0000_7fff, 32'hffff_8000, 32'h0000_0000, 1'b1);
    configure(dmx_pkg::FMT_INT16, 4'd3);
    push_words(32'h0000_7fff, 32'h0000_7fff, 32'h0000_8000, 1'b0);

    // int32 extremes, zero channels read as one, count past the maximum
    configure(dmx_pkg::FMT_INT32, 4'd8);
    push_words(dmx_pkg::Q31_MAX, dmx_pkg::Q31_MAX, dmx_pkg::Q31_MAX, 1'b1);
    push_words(dmx_pkg::Q31_MIN, dmx_pkg::Q31_MIN, dmx_pkg::Q31_MIN, 1'b0);
    push_words(dmx_pkg::Q31_MAX, 32'hffff_ffff, dmx_pkg::Q31_MIN, 1'b1);
    configure(dmx_pkg::FMT_INT32, 4'd0);
    push_words(dmx_pkg::Q31_MIN, dmx_pkg::Q31_MAX, dmx_pkg::Q31_MAX, 1'b0);
    configure(dmx_pkg::FMT_INT32, 4'd15);
    push_words(32'h0000_0007, 32'hffff_fff0, dmx_pkg::Q31_MAX, 1'b1);

    // float specials on a single lane, then on two and eight lanes
    configure(dmx_pkg::FMT_FLOAT32, 4'd1);
    push_words(32'h3f80_0000, 32'h0, 32'h0, 1'b0);  // +1.0 saturates
    push_words(32'hbf80_0000, 32'h0, 32'h0, 1'b1);  // -1.0 fits exactly
    push_words(32'h7f80_0000, 32'h0, 32'h0, 1'b0);
    push_words(32'hff80_0000, 32'h0, 32'h0, 1'b1);
    push_words(32'h7fc0_0000, 32'h0, 32'h0, 1'b0);
    push_words(32'h0000_0001, 32'h0, 32'h0, 1'b1);
    push_words(32'h3000_0000, 32'h0, 32'h0, 1'b0);  // exactly one LSB
    push_words(32'h2f80_0000, 32'h0, 32'h0, 1'b1);  // half an LSB
    push_words(32'hbf00_0000, 32'h0, 32'h0, 1'b0);
    configure(dmx_pkg::FMT_FLOAT32, 4'd2);
    push_words(32'h7f80_0000, 32'hff80_0000, 32'h0, 1'b1);  // infinities cancel
    push_words(32'h3f80_0000, 32'h3f80_0000, 32'h0, 1'b0);
    push_words(32'h5f00_0000, 32'h5f00_0000, 32'h0, 1'b1);  // huge lanes clamp
    configure(dmx_pkg::FMT_FLOAT32, 4'd8);
    push_words(32'hff80_0000, 32'hff80_0000, 32'hff80_0000, 1'b0);

    // unsupported format gives silence
    configure(dmx_pkg::FMT_NONE, 4'd4);
    push_words(32'h3f80_0000, dmx_pkg::Q31_MAX, 32'h1234_5678, 1'b1);
    push_words(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);

    // random phases over formats, counts and idling modes
    for (int k = 0; k < RAND_PHASES; k++) begin
      configure(fmt_plan[k % 4], 4'(cnt_plan[k]));
      mode = (k + k / 4) % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      base = frames_accepted;
      repeat (PHASE_ITEMS) push_frame(gen_frame(fmt_plan[k % 4]));
      if (k == 5) begin
        // output held off long enough to back up the whole pipeline
        while (frames_accepted < base + 30) @(posedge clk_i);
        stall_req++;
      end
      if (k == 10) begin
        // sender stops until every outstanding result is back
        while (frames_accepted < base + 50) @(posedge clk_i);
        send_hold = 1'b1;
        while (offering || mono_exp_q.size() != 0) @(posedge clk_i);
        send_hold = 1'b0;
      end
    end

    wait_idle();
    $display("Covered %0d frames in float32, int16, int32 and silent modes over %0d settings,",
             frames_accepted, settings_used);
    $display("with random gaps, output stalls and a full-pipeline hold; %0d results checked.",
             results_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/dmx_pkg.sv
src/dmx_lane.sv
src/dmx_sum.sv
src/dmx_div.sv
src/multichannel_mono_downmix.sv
src/dmx_checker.sv
dv/tb.sv
